// File: hw/rtl/cft_pkg.sv
package cft_pkg;

    // Byte constants
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_QUOTE = 8'd34;

    // Configuration map: one 32-bit register, word index in paddr[2]
    localparam int unsigned ADDR_W        = 3;
    localparam int unsigned DATA_W        = 32;
    localparam logic        REG_SEPARATOR = 1'b0;

    // Decoupling queue between classifier and emitter
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_CHAR       = 2'd0,
        KIND_FIELD_END  = 2'd1,
        KIND_RECORD_END = 2'd2
    } kind_t;

    typedef enum logic [4:0] {
        MODE_LINE_START  = 5'b00001,
        MODE_FIELD_START = 5'b00010,
        MODE_PLAIN       = 5'b00100,
        MODE_QUOTED      = 5'b01000,
        MODE_QUOTE_SEEN  = 5'b10000
    } mode_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_value;
        logic [7:0] field_index;
    } result_t;

    // One classified input: one or two results
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        sat_inc = (v == 8'd255) ? 8'd255 : v + 8'd1;
    endfunction

endpackage

// File: hw/rtl/cft_text_if.sv
interface cft_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

// File: hw/rtl/cft_token_if.sv
interface cft_token_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] char_value;
    logic [7:0] field_index;
    logic       last;

    modport source (output valid, output kind, output char_value, output field_index,
                    output last, input ready);
    modport sink   (input valid, input kind, input char_value, input field_index,
                    input last, output ready);
endinterface

// File: hw/rtl/cft_front.sv
module cft_front
(
    input  logic            clk,
    input  logic            rst_n,
    cft_text_if.sink        text,
    input  logic [7:0]      separator,
    input  logic            push_ready,
    output cft_pkg::push_t  push
);

    cft_pkg::mode_t mode_reg, mode_next;
    logic           cr_seen_reg, cr_seen_next;
    logic [7:0]     field_cnt_reg, field_cnt_next;

    logic            accept;
    logic [1:0]      n_res;
    cft_pkg::entry_t entry;
    logic [7:0]      b;
    logic            do_end_record;
    logic            do_end_field;
    logic            do_char;

    assign text.ready = push_ready;
    assign accept     = text.valid && push_ready;
    assign b          = text.data_byte;

    // Classify the byte against the current mode
    always_comb
    begin
        mode_next      = mode_reg;
        cr_seen_next   = cr_seen_reg;
        field_cnt_next = field_cnt_reg;
        do_end_record  = 1'b0;
        do_end_field   = 1'b0;
        do_char        = 1'b0;

        if (text.end_of_input)
        begin
            cr_seen_next = 1'b0;
            if (mode_reg != cft_pkg::MODE_LINE_START)
            begin
                do_end_record = 1'b1;
            end
            mode_next      = cft_pkg::MODE_LINE_START;
            field_cnt_next = 8'd0;
        end
        else if (cr_seen_reg && b == cft_pkg::CH_LF)
        begin
            cr_seen_next = 1'b0;
        end
        else if (b == cft_pkg::CH_CR || b == cft_pkg::CH_LF)
        begin
            do_end_record  = 1'b1;
            cr_seen_next   = (b == cft_pkg::CH_CR);
            mode_next      = cft_pkg::MODE_LINE_START;
            field_cnt_next = 8'd0;
        end
        else
        begin
            cr_seen_next = 1'b0;
            unique case (mode_reg) inside
                cft_pkg::MODE_LINE_START, cft_pkg::MODE_FIELD_START:
                begin
                    if (b == cft_pkg::CH_QUOTE)
                    begin
                        mode_next = cft_pkg::MODE_QUOTED;
                    end
                    else if (b == separator)
                    begin
                        do_end_field = 1'b1;
                    end
                    else
                    begin
                        do_char   = 1'b1;
                        mode_next = cft_pkg::MODE_PLAIN;
                    end
                end
                cft_pkg::MODE_QUOTED:
                begin
                    if (b == cft_pkg::CH_QUOTE)
                    begin
                        mode_next = cft_pkg::MODE_QUOTE_SEEN;
                    end
                    else
                    begin
                        do_char = 1'b1;
                    end
                end
                cft_pkg::MODE_QUOTE_SEEN:
                begin
                    if (b == cft_pkg::CH_QUOTE)
                    begin
                        do_char   = 1'b1;
                        mode_next = cft_pkg::MODE_QUOTED;
                    end
                    else if (b == separator)
                    begin
                        do_end_field = 1'b1;
                    end
                    else
                    begin
                        do_char   = 1'b1;
                        mode_next = cft_pkg::MODE_PLAIN;
                    end
                end
                default:
                begin
                    if (b == separator)
                    begin
                        do_end_field = 1'b1;
                    end
                    else
                    begin
                        do_char   = 1'b1;
                        mode_next = cft_pkg::MODE_PLAIN;
                    end
                end
            endcase
            if (do_end_field)
            begin
                field_cnt_next = cft_pkg::sat_inc(field_cnt_reg);
                mode_next      = cft_pkg::MODE_FIELD_START;
            end
        end
    end

    // Build the result beats for this byte
    always_comb
    begin
        entry                   = '0;
        entry.r0.kind           = cft_pkg::KIND_CHAR;
        entry.r1.kind           = cft_pkg::KIND_CHAR;
        entry.r0.field_index    = field_cnt_reg;
        n_res                   = 2'd0;
        if (do_end_record)
        begin
            if (mode_reg == cft_pkg::MODE_LINE_START)
            begin
                entry.r0.kind        = cft_pkg::KIND_RECORD_END;
                entry.r0.field_index = 8'd0;
                n_res                = 2'd1;
            end
            else
            begin
                entry.two            = 1'b1;
                entry.r0.kind        = cft_pkg::KIND_FIELD_END;
                entry.r1.kind        = cft_pkg::KIND_RECORD_END;
                entry.r1.field_index = cft_pkg::sat_inc(field_cnt_reg);
                n_res                = 2'd2;
            end
        end
        else if (do_end_field)
        begin
            entry.r0.kind = cft_pkg::KIND_FIELD_END;
            n_res         = 2'd1;
        end
        else if (do_char)
        begin
            entry.r0.char_value = b;
            n_res               = 2'd1;
        end
    end

    assign push.valid = accept && (n_res != 2'd0);
    assign push.entry = entry;

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= cft_pkg::MODE_LINE_START;
            cr_seen_reg   <= 1'b0;
            field_cnt_reg <= 8'd0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            cr_seen_reg   <= cr_seen_next;
            field_cnt_reg <= field_cnt_next;
        end
    end

endmodule

// File: hw/rtl/cft_queue.sv
module cft_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  cft_pkg::push_t  push,
    output logic            push_ready,
    output cft_pkg::head_t  head,
    input  logic            pop
);

    cft_pkg::entry_t                 mem_reg [cft_pkg::QUEUE_DEPTH];
    logic [cft_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [cft_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                            do_push, do_pop;

    assign push_ready = (count_reg != cft_pkg::QCNT_W'(cft_pkg::QUEUE_DEPTH));
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/cft_back.sv
module cft_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  cft_pkg::head_t  head,
    output logic            pop,
    cft_token_if.source     token
);

    logic              out_valid_reg, out_valid_next;
    cft_pkg::result_t  out_res_reg, out_res_next;
    logic              out_last_reg, out_last_next;
    logic              phase_reg, phase_next;
    logic              load;

    // Output slot is free or drains this cycle
    assign load = !out_valid_reg || token.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_last_next  = out_last_reg;
        phase_next     = phase_reg;
        pop            = 1'b0;
        if (load)
        begin
            if (phase_reg)
            begin
                // second beat of a two-result entry
                out_valid_next = 1'b1;
                out_res_next   = head.entry.r1;
                out_last_next  = 1'b1;
                pop            = 1'b1;
                phase_next     = 1'b0;
            end
            else if (head.valid)
            begin
                out_valid_next = 1'b1;
                out_res_next   = head.entry.r0;
                out_last_next  = !head.entry.two;
                pop            = !head.entry.two;
                phase_next     = head.entry.two;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
    end

    assign token.valid       = out_valid_reg;
    assign token.kind        = out_res_reg.kind;
    assign token.char_value  = out_res_reg.char_value;
    assign token.field_index = out_res_reg.field_index;
    assign token.last        = out_last_reg;

endmodule

// File: hw/rtl/csv_field_tokenizer.sv
// Path: the classifier writes an accepted byte's results into the queue;
// the first result beat then moves from queue to output register.
// Throughput: one byte per cycle while the queue has room; a byte that ends
// a nonempty record gives two beats through the single output register.
// Reset (rst_n, async, active low): line-start mode, field count 0, queue and
// output empty, separator back to comma.
module csv_field_tokenizer
(
    input  logic                          clk,
    input  logic                          rst_n,
    cft_text_if.sink                      text,
    cft_token_if.source                   token,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cft_pkg::ADDR_W-1:0]    paddr,
    input  logic [cft_pkg::DATA_W-1:0]    pwdata,
    output logic [cft_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic           [7:0] separator_reg;
    logic                 push_ready;
    logic                 pop;
    cft_pkg::push_t       push;
    cft_pkg::head_t       head;
    logic                 reg_sel;

    // Register file
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == cft_pkg::REG_SEPARATOR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg <= cft_pkg::CH_COMMA;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            separator_reg <= pwdata[7:0];
        end
    end

    assign prdata = reg_sel ? {{(cft_pkg::DATA_W-8){1'b0}}, separator_reg} : '0;

    cft_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .separator  (separator_reg),
        .push_ready (push_ready),
        .push       (push)
    );

    cft_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    cft_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .token (token)
    );

endmodule

// File: hw/rtl/cft_checker.sv
module cft_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    input  logic       ready,
    input  logic [1:0] kind,
    input  logic [7:0] char_value,
    input  logic [7:0] field_index,
    input  logic       last
);

    // A stalled beat stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("token beat dropped while stalled");

    // Kind code 3 is never produced
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (kind != 2'd3))
        else $error("illegal token kind");

    // Only field characters carry a character
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (kind != cft_pkg::KIND_CHAR) |-> (char_value == 8'd0))
        else $error("nonzero char on a field or record end");

    // Record end always closes the beats of its byte
    a_rec_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (kind == cft_pkg::KIND_RECORD_END) |-> last)
        else $error("record end not marked last");

    // field_index of a stalled beat holds
    a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> $stable(field_index))
        else $error("field index changed while stalled");

endmodule

bind csv_field_tokenizer cft_checker u_cft_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (token.valid),
    .ready       (token.ready),
    .kind        (token.kind),
    .char_value  (token.char_value),
    .field_index (token.field_index),
    .last        (token.last)
);

// File: bench/csv_field_tokenizer_checker.sv
`timescale 1ns / 100ps

module csv_field_tokenizer_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    cft_text_if                           text_mon,
    cft_token_if                          token_mon,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [cft_pkg::ADDR_W-1:0]    paddr,
    input  logic [cft_pkg::DATA_W-1:0]    pwdata,
    input  logic [cft_pkg::DATA_W-1:0]    prdata,
    output int                            err_count,
    output int                            pending,
    output int                            beats_checked,
    output int                            records_checked
);

    typedef struct packed {
        cft_pkg::kind_t kind;
        logic [7:0]     char_value;
        logic [7:0]     field_index;
        logic           last;
    } token_beat_t;

    // Shadow of the parser state and the separator register
    logic [7:0]     sep_byte;
    cft_pkg::mode_t mode;
    logic           cr_seen;
    logic [7:0]     fld_cnt;

    token_beat_t    expected_tokens[$];
    token_beat_t    exp_beat;

    function automatic token_beat_t beat_of(input cft_pkg::kind_t kind,
                                            input logic [7:0] ch,
                                            input logic [7:0] idx);
        token_beat_t t;
        t.kind        = kind;
        t.char_value  = ch;
        t.field_index = idx;
        t.last        = 1'b0;
        return t;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        err_count++;
    endtask

    // Work out the token beats caused by one text beat
    task automatic tokenize_byte(input logic [7:0] b, input logic eoi);
        token_beat_t got[2];
        int          n;
        logic [7:0]  nxt;
        logic        split;
        n     = 0;
        split = 1'b0;
        nxt   = (fld_cnt == 8'd255) ? 8'd255 : fld_cnt + 8'd1;
        if (eoi)
        begin
            // flush an open record
            cr_seen = 1'b0;
            if (mode != cft_pkg::MODE_LINE_START)
            begin
                got[0] = beat_of(cft_pkg::KIND_FIELD_END, 8'd0, fld_cnt);
                got[1] = beat_of(cft_pkg::KIND_RECORD_END, 8'd0, nxt);
                n = 2;
            end
            mode    = cft_pkg::MODE_LINE_START;
            fld_cnt = 8'd0;
        end
        else if (cr_seen && b == cft_pkg::CH_LF)
        begin
            // LF of a CR LF pair, already ended
            cr_seen = 1'b0;
        end
        else
        begin
            cr_seen = 1'b0;
            if (b == cft_pkg::CH_CR || b == cft_pkg::CH_LF)
            begin
                // line end wins over separator and quotes
                if (mode == cft_pkg::MODE_LINE_START)
                begin
                    got[0] = beat_of(cft_pkg::KIND_RECORD_END, 8'd0, 8'd0);
                    n = 1;
                end
                else
                begin
                    got[0] = beat_of(cft_pkg::KIND_FIELD_END, 8'd0, fld_cnt);
                    got[1] = beat_of(cft_pkg::KIND_RECORD_END, 8'd0, nxt);
                    n = 2;
                end
                mode    = cft_pkg::MODE_LINE_START;
                fld_cnt = 8'd0;
                cr_seen = (b == cft_pkg::CH_CR);
            end
            else
            begin
                case (mode) inside
                    cft_pkg::MODE_LINE_START, cft_pkg::MODE_FIELD_START:
                    begin
                        if (b == cft_pkg::CH_QUOTE)
                        begin
                            mode = cft_pkg::MODE_QUOTED;
                        end
                        else if (b == sep_byte)
                        begin
                            split = 1'b1;
                        end
                        else
                        begin
                            got[0] = beat_of(cft_pkg::KIND_CHAR, b, fld_cnt);
                            n = 1;
                            mode = cft_pkg::MODE_PLAIN;
                        end
                    end
                    cft_pkg::MODE_QUOTED:
                    begin
                        if (b == cft_pkg::CH_QUOTE)
                        begin
                            mode = cft_pkg::MODE_QUOTE_SEEN;
                        end
                        else
                        begin
                            got[0] = beat_of(cft_pkg::KIND_CHAR, b, fld_cnt);
                            n = 1;
                        end
                    end
                    cft_pkg::MODE_QUOTE_SEEN:
                    begin
                        if (b == cft_pkg::CH_QUOTE)
                        begin
                            // doubled quote gives one quote
                            got[0] = beat_of(cft_pkg::KIND_CHAR, b, fld_cnt);
                            n = 1;
                            mode = cft_pkg::MODE_QUOTED;
                        end
                        else if (b == sep_byte)
                        begin
                            split = 1'b1;
                        end
                        else
                        begin
                            got[0] = beat_of(cft_pkg::KIND_CHAR, b, fld_cnt);
                            n = 1;
                            mode = cft_pkg::MODE_PLAIN;
                        end
                    end
                    default:
                    begin
                        if (b == sep_byte)
                        begin
                            split = 1'b1;
                        end
                        else
                        begin
                            got[0] = beat_of(cft_pkg::KIND_CHAR, b, fld_cnt);
                            n = 1;
                            mode = cft_pkg::MODE_PLAIN;
                        end
                    end
                endcase
                if (split)
                begin
                    got[0]  = beat_of(cft_pkg::KIND_FIELD_END, 8'd0, fld_cnt);
                    n       = 1;
                    fld_cnt = nxt;
                    mode    = cft_pkg::MODE_FIELD_START;
                end
            end
        end
        if (n > 0)
            got[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_tokens.push_back(got[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_byte        = cft_pkg::CH_COMMA;
            mode            = cft_pkg::MODE_LINE_START;
            cr_seen         = 1'b0;
            fld_cnt         = 8'd0;
            err_count       = 0;
            beats_checked   = 0;
            records_checked = 0;
            expected_tokens.delete();
        end
        else
        begin
            // register port: writes update the shadow, reads are compared
            if (psel && penable && pready && paddr[2] == cft_pkg::REG_SEPARATOR)
            begin
                if (pwrite)
                    sep_byte = pwdata[7:0];
                else if (prdata[7:0] !== sep_byte)
                    report_mismatch($sformatf("separator read %02h, expected %02h",
                                              prdata[7:0], sep_byte));
            end

            if (text_mon.valid && text_mon.ready)
                tokenize_byte(text_mon.data_byte, text_mon.end_of_input);

            // token beat against the oldest expectation
            if (token_mon.valid && token_mon.ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    report_mismatch($sformatf(
                        "unexpected beat kind=%0d char=%02h field=%0d last=%0b",
                        token_mon.kind, token_mon.char_value,
                        token_mon.field_index, token_mon.last));
                end
                else
                begin
                    exp_beat = expected_tokens.pop_front();
                    if (token_mon.kind !== exp_beat.kind ||
                        token_mon.char_value !== exp_beat.char_value ||
                        token_mon.field_index !== exp_beat.field_index ||
                        token_mon.last !== exp_beat.last)
                        report_mismatch($sformatf(
                            "beat kind=%0d char=%02h field=%0d last=%0b, expected %0d %02h %0d %0b",
                            token_mon.kind, token_mon.char_value, token_mon.field_index,
                            token_mon.last, exp_beat.kind, exp_beat.char_value,
                            exp_beat.field_index, exp_beat.last));
                    beats_checked++;
                    if (exp_beat.kind == cft_pkg::KIND_RECORD_END)
                        records_checked++;
                end
            end
        end
        pending = expected_tokens.size();
    end

endmodule

// File: bench/csv_field_tokenizer_tb.sv
`timescale 1ns / 100ps

module csv_field_tokenizer_tb;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [cft_pkg::ADDR_W-1:0] paddr;
    logic [cft_pkg::DATA_W-1:0] pwdata;
    logic [cft_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    int         err_count;
    int         pending;
    int         beats_checked;
    int         records_checked;
    int         bytes_sent;
    int         settings_used;
    logic [7:0] sep_now;
    bit         calm;

    cft_text_if  text_ch();
    cft_token_if token_ch();

    csv_field_tokenizer uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text_ch),
        .token   (token_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    csv_field_tokenizer_checker chk
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .text_mon        (text_ch),
        .token_mon       (token_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .err_count       (err_count),
        .pending         (pending),
        .beats_checked   (beats_checked),
        .records_checked (records_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #4_000_000;
        $display("Timeout with %0d token beats still expected", pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Token sink: after each accepted beat, hold ready low for a random gap
    initial
    begin
        int gap;
        gap = 0;
        token_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (token_ch.valid && token_ch.ready)
                gap = calm ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                token_ch.ready <= 1'b0;
                gap--;
            end
            else
            begin
                token_ch.ready <= 1'b1;
            end
        end
    end

    // One text beat, after a random idle gap
    task automatic send_text(input logic [7:0] b, input logic eoi);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid        <= 1'b1;
        text_ch.data_byte    <= b;
        text_ch.end_of_input <= eoi;
        do @(posedge clk); while (!text_ch.ready);
        bytes_sent++;
    endtask

    // Stop sending and wait until every expected beat has come out
    task automatic drain();
        text_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [cft_pkg::DATA_W-1:0] wdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {cft_pkg::REG_SEPARATOR, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_separator(input logic [7:0] value);
        drain();
        apb_access(1'b1, {24'd0, value});
        apb_access(1'b0, '0);
        sep_now = value;
        settings_used++;
    endtask

    // Byte with no special meaning under the current separator
    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == sep_now || c == cft_pkg::CH_QUOTE ||
               c == cft_pkg::CH_CR || c == cft_pkg::CH_LF);
        return c;
    endfunction

    // Mostly well-formed record: plain and quoted fields, random line end
    task automatic send_record();
        int nfields;
        int len;
        int pick;
        calm    = ($urandom_range(0, 5) == 0);
        nfields = $urandom_range(0, 5);
        for (int i = 0; i < nfields; i++)
        begin
            if (i > 0)
                send_text(sep_now, 1'b0);
            len = $urandom_range(0, 4);
            if ($urandom_range(0, 2) == 0)
            begin
                send_text(cft_pkg::CH_QUOTE, 1'b0);
                for (int j = 0; j < len; j++)
                begin
                    pick = $urandom_range(0, 5);
                    if (pick == 0)
                    begin
                        send_text(sep_now, 1'b0);
                    end
                    else if (pick == 1)
                    begin
                        send_text(cft_pkg::CH_QUOTE, 1'b0);
                        send_text(cft_pkg::CH_QUOTE, 1'b0);
                    end
                    else
                    begin
                        send_text(plain_byte(), 1'b0);
                    end
                end
                send_text(cft_pkg::CH_QUOTE, 1'b0);
                // text after the closing quote
                if ($urandom_range(0, 3) == 0)
                    send_text(plain_byte(), 1'b0);
            end
            else
            begin
                for (int j = 0; j < len; j++)
                    send_text(plain_byte(), 1'b0);
            end
        end
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            send_text(cft_pkg::CH_LF, 1'b0);
        end
        else if (pick < 7)
        begin
            send_text(cft_pkg::CH_CR, 1'b0);
            send_text(cft_pkg::CH_LF, 1'b0);
        end
        else if (pick == 7)
        begin
            send_text(cft_pkg::CH_CR, 1'b0);
        end
        else if (pick == 8)
        begin
            send_text(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // Noise: random bytes biased toward the special ones
    task automatic send_noise();
        int         len;
        logic [7:0] c;
        calm = 1'b0;
        len  = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 7))
                0:       c = sep_now;
                1:       c = cft_pkg::CH_QUOTE;
                2:       c = cft_pkg::CH_CR;
                3:       c = cft_pkg::CH_LF;
                default: c = 8'($urandom_range(0, 255));
            endcase
            send_text(c, $urandom_range(0, 15) == 0);
        end
    endtask

    initial
    begin
        logic [7:0] sep_list[8];
        int         phase_start;

        rst_n                = 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        text_ch.valid       <= 1'b0;
        text_ch.data_byte   <= 8'd0;
        text_ch.end_of_input <= 1'b0;
        bytes_sent          = 0;
        settings_used       = 1;
        sep_now             = cft_pkg::CH_COMMA;
        calm                = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: quoting, line ends, flushes, byte extremes (comma after reset)
        send_text("a", 1'b0);
        send_text(cft_pkg::CH_COMMA, 1'b0);
        send_text(cft_pkg::CH_QUOTE, 1'b0);
        send_text(cft_pkg::CH_COMMA, 1'b0);      // literal inside quotes
        send_text(cft_pkg::CH_QUOTE, 1'b0);
        send_text(cft_pkg::CH_QUOTE, 1'b0);      // doubled quote
        send_text(cft_pkg::CH_QUOTE, 1'b0);      // closing quote
        send_text("x", 1'b0);                    // appended after close
        send_text(cft_pkg::CH_COMMA, 1'b0);
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b0);
        send_text(cft_pkg::CH_CR, 1'b0);
        send_text(cft_pkg::CH_LF, 1'b0);         // swallowed after CR
        send_text(cft_pkg::CH_LF, 1'b0);         // empty record
        send_text(cft_pkg::CH_CR, 1'b0);
        send_text(cft_pkg::CH_CR, 1'b0);         // CR CR gives an empty record
        send_text(cft_pkg::CH_QUOTE, 1'b0);
        send_text("q", 1'b0);
        send_text(cft_pkg::CH_LF, 1'b0);         // unclosed quote ends at line end
        send_text(cft_pkg::CH_QUOTE, 1'b0);
        send_text(8'hFF, 1'b1);                  // flush of an open quote
        send_text(8'h00, 1'b1);                  // flush at line start: nothing
        send_text(cft_pkg::CH_COMMA, 1'b0);      // empty first field
        send_text(8'hA5, 1'b1);

        // Random phases under several separators
        sep_list = '{8'd0, 8'd255, cft_pkg::CH_CR, cft_pkg::CH_LF,
                     cft_pkg::CH_QUOTE, 8'd9, 8'd0, cft_pkg::CH_COMMA};
        sep_list[6] = 8'($urandom_range(0, 255));
        foreach (sep_list[p])
        begin
            set_separator(sep_list[p]);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 170)
            begin
                if ($urandom_range(0, 9) < 8)
                    send_record();
                else
                    send_noise();
            end
        end

        // Long record to drive the field number into saturation
        calm = 1'b1;
        for (int i = 0; i < 262; i++)
        begin
            if (i % 16 == 0)
                send_text(plain_byte(), 1'b0);
            send_text(cft_pkg::CH_COMMA, 1'b0);
        end
        send_text(cft_pkg::CH_CR, 1'b0);
        send_text(cft_pkg::CH_LF, 1'b0);

        drain();
        $display("Summary: %0d text beats sent under %0d separator settings",
                 bytes_sent, settings_used);
        $display("Summary: %0d token beats checked, %0d records ended",
                 beats_checked, records_checked);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/cft_pkg.sv
hw/rtl/cft_text_if.sv
hw/rtl/cft_token_if.sv
hw/rtl/cft_front.sv
hw/rtl/cft_queue.sv
hw/rtl/cft_back.sv
hw/rtl/csv_field_tokenizer.sv
hw/rtl/cft_checker.sv
bench/csv_field_tokenizer_checker.sv
bench/csv_field_tokenizer_tb.sv
